@@ hdl/ifhc_pkg.sv @@
// ----------------------------------------------------------------------------
// ifhc_pkg
// Types, codes and helpers shared by the IPv4 flow header classifier.
// ----------------------------------------------------------------------------
package ifhc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int LEN_W       = COUNT_WIDTH + 1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [LEN_W-1:0]       len_t;

  localparam count_t COUNT_MAX = '1;

  // link header
  localparam logic [15:0] IPV4_TYPE  = 16'h0800;
  localparam logic [4:0]  ETH_HDR    = 5'd14;
  localparam logic [4:0]  COOKED_HDR = 5'd16;
  localparam logic [5:0]  IP_HDR_MIN = 6'd20;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [7:0] TLS_HANDSHAKE    = 8'h16;
  localparam logic [7:0] TLS_CLIENT_HELLO = 8'h01;

  // lowercase payload patterns
  localparam logic [39:0] STR_HTTP = 40'h687474702F;  // "http/"
  localparam logic [39:0] STR_POST = 40'h706F737420;  // "post "
  localparam logic [31:0] STR_GET  = 32'h67657420;    // "get "
  localparam logic [23:0] STR_FTP  = 24'h667470;      // "ftp"
  localparam logic [23:0] STR_DNS  = 24'h646E73;      // "dns"

  // result codes
  localparam logic [1:0] LINK_NONE   = 2'd0;
  localparam logic [1:0] LINK_ETH    = 2'd1;
  localparam logic [1:0] LINK_COOKED = 2'd2;

  localparam logic [1:0] NET_TCP   = 2'd0;
  localparam logic [1:0] NET_UDP   = 2'd1;
  localparam logic [1:0] NET_OTHER = 2'd2;

  localparam logic [1:0] TRN_NONE = 2'd0;
  localparam logic [1:0] TRN_TCP  = 2'd1;
  localparam logic [1:0] TRN_UDP  = 2'd2;

  localparam logic [2:0] APP_UNKNOWN = 3'd0;
  localparam logic [2:0] APP_HTTPS   = 3'd1;
  localparam logic [2:0] APP_HTTP    = 3'd2;
  localparam logic [2:0] APP_FTP     = 3'd3;
  localparam logic [2:0] APP_DNS     = 3'd4;

  // configuration registers
  localparam logic [1:0] CFG_HTTPS_PORT = 2'd0;
  localparam logic [1:0] CFG_FTP_PORT   = 2'd1;
  localparam logic [1:0] CFG_DNS_PORT   = 2'd2;

  localparam logic [15:0] HTTPS_PORT_RST = 16'd443;
  localparam logic [15:0] FTP_PORT_RST   = 16'd21;
  localparam logic [15:0] DNS_PORT_RST   = 16'd53;

  typedef struct packed {
    logic [15:0] https_port;
    logic [15:0] ftp_port;
    logic [15:0] dns_port;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic        frame_valid;
    logic [1:0]  link_kind;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [1:0]  network_kind;
    logic [1:0]  transport_kind;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [2:0]  application_kind;
    logic [15:0] payload_length;
  } out_item_t;

  typedef struct packed {
    logic http;
    logic ftp;
    logic dns;
    logic tls_first;
    logic tls;
  } match_flags_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] b);
    lower_ascii = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

  function automatic logic [4:0] link_offset(input logic [1:0] kind);
    logic [4:0] off;
    unique case (kind)
      LINK_ETH:    off = ETH_HDR;
      LINK_COOKED: off = COOKED_HDR;
      default:     off = 5'd0;
    endcase
    link_offset = off;
  endfunction

endpackage

@@ hdl/ifhc_parser.sv @@
// ----------------------------------------------------------------------------
// ifhc_parser
// Per-byte frame state: link detect, IPv4 and transport header capture,
// payload pattern flags, and the frame summary computed on the last byte.
// ----------------------------------------------------------------------------
module ifhc_parser import ifhc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  count_t       cnt_r, cnt_nxt;
  logic [1:0]   link_r, link_nxt;
  logic [15:0]  type_r, type_nxt;
  logic [5:0]   ihl_r, ihl_nxt;
  logic [7:0]   proto_r, proto_nxt;
  logic [31:0]  src_r, src_nxt;
  logic [31:0]  dst_r, dst_nxt;
  logic [31:0]  port_r, port_nxt;
  logic [7:0]   pstart_r, pstart_nxt;
  logic         armed_r, armed_nxt;
  logic [39:0]  recent_r, recent_nxt;
  match_flags_t flags_r, flags_nxt;

  count_t      pos, rel, trel, idx;
  logic [7:0]  b;
  logic [4:0]  loff;
  logic        hdr_act, trn_act, pl_act;
  logic [3:0]  doff;
  logic [39:0] win;

  len_t        len, tstart, plen_full;
  logic        ok;
  logic [1:0]  net, tk;
  logic [15:0] sp, dp;

  always_comb begin
    pos = cnt_r;
    b   = item.data_byte;

    cnt_nxt    = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 1'b1;
    type_nxt   = type_r;
    link_nxt   = link_r;
    ihl_nxt    = ihl_r;
    proto_nxt  = proto_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    port_nxt   = port_r;
    pstart_nxt = pstart_r;
    armed_nxt  = armed_r;
    recent_nxt = recent_r;
    flags_nxt  = flags_r;

    if (pos >= count_t'(12) && pos <= count_t'(15)) begin
      type_nxt = {type_r[7:0], b};
    end
    if (pos == count_t'(13) && type_nxt == IPV4_TYPE) begin
      link_nxt = LINK_ETH;
    end
    if (pos == count_t'(15) && link_r == LINK_NONE && type_nxt == IPV4_TYPE) begin
      link_nxt = LINK_COOKED;
    end

    loff    = link_offset(link_nxt);
    hdr_act = (link_nxt != LINK_NONE) && (pos >= count_t'(loff));
    rel     = pos - count_t'(loff);

    if (hdr_act) begin
      if (rel == count_t'(0)) begin
        ihl_nxt = {b[3:0], 2'b00};
      end else if (rel == count_t'(9)) begin
        proto_nxt = b;
        if (b == PROTO_UDP && ihl_r >= IP_HDR_MIN) begin
          pstart_nxt = 8'(loff) + 8'(ihl_r) + 8'd8;
          armed_nxt  = 1'b1;
        end
      end else if (rel >= count_t'(12) && rel <= count_t'(15)) begin
        src_nxt = {src_r[23:0], b};
      end else if (rel >= count_t'(16) && rel <= count_t'(19)) begin
        dst_nxt = {dst_r[23:0], b};
      end
    end

    trn_act = hdr_act && (ihl_nxt >= IP_HDR_MIN) && (rel >= count_t'(ihl_nxt));
    trel    = rel - count_t'(ihl_nxt);
    doff    = (b[7:4] < 4'd5) ? 4'd5 : b[7:4];
    if (trn_act) begin
      if (trel <= count_t'(3)) begin
        port_nxt = {port_r[23:0], b};
      end
      if (trel == count_t'(12) && proto_nxt == PROTO_TCP) begin
        pstart_nxt = 8'(loff) + 8'(ihl_nxt) + {2'b00, doff, 2'b00};
        armed_nxt  = 1'b1;
      end
    end

    // arming always lands past the current byte, so the stored start suffices
    pl_act = hdr_act && armed_r && (pos >= count_t'(pstart_r));
    idx    = pos - count_t'(pstart_r);
    win    = {recent_r[31:0], lower_ascii(b)};
    if (pl_act) begin
      recent_nxt = win;
      if (idx == count_t'(0) && b == TLS_HANDSHAKE) begin
        flags_nxt.tls_first = 1'b1;
      end
      if (idx == count_t'(5) && b == TLS_CLIENT_HELLO && flags_r.tls_first) begin
        flags_nxt.tls = 1'b1;
      end
      if (idx >= count_t'(4) && (win == STR_HTTP || win == STR_POST)) begin
        flags_nxt.http = 1'b1;
      end
      if (idx >= count_t'(3) && win[31:0] == STR_GET) begin
        flags_nxt.http = 1'b1;
      end
      if (idx >= count_t'(2) && win[23:0] == STR_FTP) begin
        flags_nxt.ftp = 1'b1;
      end
      if (idx >= count_t'(2) && win[23:0] == STR_DNS) begin
        flags_nxt.dns = 1'b1;
      end
    end
  end

  // frame summary, valid when the current byte is the last one
  always_comb begin
    len       = len_t'(pos) + len_t'(1);
    tstart    = len_t'(loff) + len_t'(ihl_nxt);
    ok        = (link_nxt != LINK_NONE) && (ihl_nxt >= IP_HDR_MIN) &&
                (len >= len_t'(loff) + len_t'(20)) && (len >= tstart);
    net       = (proto_nxt == PROTO_TCP) ? NET_TCP :
                (proto_nxt == PROTO_UDP) ? NET_UDP : NET_OTHER;
    tk        = TRN_NONE;
    if (net == NET_TCP && len >= tstart + len_t'(20)) begin
      tk = TRN_TCP;
    end else if (net == NET_UDP && len >= tstart + len_t'(8)) begin
      tk = TRN_UDP;
    end
    sp        = port_nxt[31:16];
    dp        = port_nxt[15:0];
    plen_full = len - len_t'(pstart_nxt);

    result = '0;
    if (ok) begin
      result.frame_valid         = 1'b1;
      result.link_kind           = link_nxt;
      result.source_address      = src_nxt;
      result.destination_address = dst_nxt;
      result.network_kind        = net;
      result.transport_kind      = tk;
      if (tk != TRN_NONE) begin
        result.source_port      = sp;
        result.destination_port = dp;
        if (armed_nxt && len > len_t'(pstart_nxt)) begin
          result.payload_length = (32'(plen_full) > 32'hFFFF) ? 16'hFFFF :
                                  16'(plen_full);
        end
      end
      if (tk == TRN_TCP) begin
        if (flags_nxt.tls || sp == cfg.https_port || dp == cfg.https_port) begin
          result.application_kind = APP_HTTPS;
        end else if (flags_nxt.http) begin
          result.application_kind = APP_HTTP;
        end else if (sp == cfg.ftp_port || dp == cfg.ftp_port || flags_nxt.ftp) begin
          result.application_kind = APP_FTP;
        end
      end else if (tk == TRN_UDP) begin
        if (sp == cfg.dns_port || dp == cfg.dns_port || flags_nxt.dns) begin
          result.application_kind = APP_DNS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && item.end_of_packet)) begin
      cnt_r    <= '0;
      link_r   <= LINK_NONE;
      type_r   <= '0;
      ihl_r    <= '0;
      proto_r  <= '0;
      src_r    <= '0;
      dst_r    <= '0;
      port_r   <= '0;
      pstart_r <= '0;
      armed_r  <= 1'b0;
      recent_r <= '0;
      flags_r  <= '0;
    end else if (fire) begin
      cnt_r    <= cnt_nxt;
      link_r   <= link_nxt;
      type_r   <= type_nxt;
      ihl_r    <= ihl_nxt;
      proto_r  <= proto_nxt;
      src_r    <= src_nxt;
      dst_r    <= dst_nxt;
      port_r   <= port_nxt;
      pstart_r <= pstart_nxt;
      armed_r  <= armed_nxt;
      recent_r <= recent_nxt;
      flags_r  <= flags_nxt;
    end
  end

endmodule

@@ hdl/ipv4_flow_header_classifier.sv @@
// ----------------------------------------------------------------------------
// ipv4_flow_header_classifier
// Classifies captured Ethernet or cooked frames carrying IPv4 TCP/UDP.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_item): one frame byte per item, with
// end_of_packet set on the frame's last byte. Output channel (out_valid/
// out_stall/out_item): one summary item per frame, issued for its last byte.
// Config port (cfg_we/cfg_index/cfg_wdata): HTTPS, FTP and DNS port numbers;
// unknown indexes are ignored. The user must write them only while no frame
// is in flight; the block itself does not enforce this.
// Throughput: one byte per cycle while in_stall is low. Each byte is held in
// an input register, then compare and counter logic updates the frame state.
// A last byte's summary is registered in the output register as it fires.
// The output register holds a summary while out_stall is high; non-final
// bytes keep flowing behind it, and in_stall rises only when a final byte
// waits for the output register.
// Reset (rst_n low, synchronous): channels empty, frame state cleared, port
// registers back to 443, 21 and 53.
// ----------------------------------------------------------------------------
module ipv4_flow_header_classifier import ifhc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic      s_valid_r;
  in_item_t  s_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  cfg_t      cfg_r;

  logic      in_acc, s_adv, fire;
  out_item_t result;

  assign s_adv    = !s_item_r.end_of_packet || !out_valid_r || !out_stall;
  assign fire     = s_valid_r && s_adv;
  assign in_stall = s_valid_r && !s_adv;
  assign in_acc   = in_valid && !in_stall;

  ifhc_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_acc) begin
      s_valid_r <= 1'b1;
    end else if (fire) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && s_item_r.end_of_packet) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s_item_r.end_of_packet) begin
      out_item_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.https_port <= HTTPS_PORT_RST;
      cfg_r.ftp_port   <= FTP_PORT_RST;
      cfg_r.dns_port   <= DNS_PORT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HTTPS_PORT: cfg_r.https_port <= cfg_wdata;
        CFG_FTP_PORT:   cfg_r.ftp_port   <= cfg_wdata;
        CFG_DNS_PORT:   cfg_r.dns_port   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ hdl/ifhc_checker.sv @@
// ----------------------------------------------------------------------------
// ifhc_checker
// Port-level checks for the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module ifhc_checker import ifhc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channels not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled item changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.frame_valid |->
      out_item.link_kind == LINK_NONE && out_item.source_address == 32'd0 &&
      out_item.destination_address == 32'd0 && out_item.network_kind == NET_TCP &&
      out_item.transport_kind == TRN_NONE && out_item.source_port == 16'd0 &&
      out_item.destination_port == 16'd0 &&
      out_item.application_kind == APP_UNKNOWN && out_item.payload_length == 16'd0)
    else $error("invalid frame item has nonzero fields");

  a_no_transport: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.transport_kind == TRN_NONE |->
      out_item.source_port == 16'd0 && out_item.destination_port == 16'd0 &&
      out_item.application_kind == APP_UNKNOWN && out_item.payload_length == 16'd0)
    else $error("transport fields set without transport header");

endmodule

bind ipv4_flow_header_classifier ifhc_checker u_ifhc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

@@ test/ipv4_flow_header_classifier_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_flow_header_classifier_test
// Self-checking bench for the IPv4 flow header classifier.
// Frames are built byte by byte (Ethernet, cooked or no link header, IPv4
// with and without options, TCP/UDP/other, payloads carrying TLS, HTTP, FTP
// and DNS cues) and streamed with random gaps and output stalls. A
// byte-level predictor of the frame state yields one expected summary per
// frame, checked field by field against the output channel.
// ----------------------------------------------------------------------------
module ipv4_flow_header_classifier_test;
  import ifhc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  ipv4_flow_header_classifier dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  in_item_t    byte_backlog[$];
  out_item_t   expected_summaries[$];
  logic [7:0]  payload_bytes[$];
  cfg_t        port_cfg = {HTTPS_PORT_RST, FTP_PORT_RST, DNS_PORT_RST};

  int          gap_odds = 0;
  int          stall_odds = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          mismatches = 0;
  int          summaries_checked = 0;
  int          bytes_sent = 0;
  int          bytes_queued = 0;
  int          settings_used = 1;
  int          app_count[8];
  int unsigned cycle_count = 0;
  out_item_t   predicted;
  out_item_t   want;

  // predictor copy of the frame state
  count_t       byte_cnt;
  logic [4:0]   lnk_off;
  logic [15:0]  eth_type;
  logic [5:0]   ihl_bytes;
  logic [7:0]   proto;
  logic [31:0]  src_ip;
  logic [31:0]  dst_ip;
  logic [31:0]  ports;
  len_t         pl_start;
  logic         pl_armed;
  logic [39:0]  window;
  match_flags_t flags;

  function automatic void clear_flow();
    byte_cnt = '0; lnk_off = '0; eth_type = '0; ihl_bytes = '0; proto = '0;
    src_ip = '0; dst_ip = '0; ports = '0; pl_start = '0; pl_armed = 1'b0;
    window = '0; flags = '0;
  endfunction

  function automatic bit classify_byte(input in_item_t it, output out_item_t res);
    int unsigned pos, rel, trel, off, idx, len, t, plen;
    logic [7:0]  b, lb;
    logic [15:0] sp, dp;
    logic [1:0]  net, tk;
    logic [2:0]  app;
    pos = byte_cnt;
    b = it.data_byte;
    res = '0;
    if (pos >= 12 && pos <= 15) eth_type = {eth_type[7:0], b};
    if (pos == 13 && eth_type == IPV4_TYPE) lnk_off = ETH_HDR;
    if (pos == 15 && lnk_off == 0 && eth_type == IPV4_TYPE) lnk_off = COOKED_HDR;
    if (lnk_off != 0 && pos >= lnk_off) begin
      rel = pos - lnk_off;
      if (rel == 0) begin
        ihl_bytes = {b[3:0], 2'b00};
      end else if (rel == 9) begin
        proto = b;
        if (b == PROTO_UDP && ihl_bytes >= IP_HDR_MIN) begin
          pl_start = len_t'(lnk_off + ihl_bytes + 8);
          pl_armed = 1'b1;
        end
      end else if (rel >= 12 && rel <= 15) begin
        src_ip = {src_ip[23:0], b};
      end else if (rel >= 16 && rel <= 19) begin
        dst_ip = {dst_ip[23:0], b};
      end
      if (ihl_bytes >= IP_HDR_MIN && rel >= ihl_bytes) begin
        trel = rel - ihl_bytes;
        if (trel <= 3) ports = {ports[23:0], b};
        if (trel == 12 && proto == PROTO_TCP) begin
          off = b[7:4];
          if (off < 5) off = 5;
          pl_start = len_t'(lnk_off + ihl_bytes + off * 4);
          pl_armed = 1'b1;
        end
      end
      if (pl_armed && pos >= pl_start) begin
        idx = pos - pl_start;
        lb = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
        window = {window[31:0], lb};
        if (idx == 0 && b == TLS_HANDSHAKE) flags.tls_first = 1'b1;
        if (idx == 5 && b == TLS_CLIENT_HELLO && flags.tls_first) flags.tls = 1'b1;
        if (idx >= 4 && (window == STR_HTTP || window == STR_POST)) flags.http = 1'b1;
        if (idx >= 3 && window[31:0] == STR_GET) flags.http = 1'b1;
        if (idx >= 2 && window[23:0] == STR_FTP) flags.ftp = 1'b1;
        if (idx >= 2 && window[23:0] == STR_DNS) flags.dns = 1'b1;
      end
    end
    if (byte_cnt != COUNT_MAX) byte_cnt++;
    if (!it.end_of_packet) return 1'b0;

    len = pos + 1;
    if (len >= COOKED_HDR && lnk_off != 0 && len - lnk_off >= 20 &&
        ihl_bytes >= IP_HDR_MIN && len - lnk_off >= ihl_bytes) begin
      net = (proto == PROTO_TCP) ? NET_TCP : (proto == PROTO_UDP) ? NET_UDP : NET_OTHER;
      t = lnk_off + ihl_bytes;
      tk = TRN_NONE; sp = '0; dp = '0; app = APP_UNKNOWN; plen = 0;
      if (net == NET_TCP && len >= t + 20) tk = TRN_TCP;
      else if (net == NET_UDP && len >= t + 8) tk = TRN_UDP;
      if (tk != TRN_NONE) begin
        sp = ports[31:16];
        dp = ports[15:0];
        if (pl_armed && len > pl_start) plen = len - pl_start;
        if (plen > 65535) plen = 65535;
      end
      if (tk == TRN_TCP) begin
        if (flags.tls || sp == port_cfg.https_port || dp == port_cfg.https_port)
          app = APP_HTTPS;
        else if (flags.http)
          app = APP_HTTP;
        else if (sp == port_cfg.ftp_port || dp == port_cfg.ftp_port || flags.ftp)
          app = APP_FTP;
      end else if (tk == TRN_UDP) begin
        if (sp == port_cfg.dns_port || dp == port_cfg.dns_port || flags.dns)
          app = APP_DNS;
      end
      res.frame_valid         = 1'b1;
      res.link_kind           = (lnk_off == ETH_HDR) ? LINK_ETH : LINK_COOKED;
      res.source_address      = src_ip;
      res.destination_address = dst_ip;
      res.network_kind        = net;
      res.transport_kind      = tk;
      res.source_port         = sp;
      res.destination_port    = dp;
      res.application_kind    = app;
      res.payload_length      = 16'(plen);
    end
    clear_flow();
    return 1'b1;
  endfunction

  // ---- frame construction ----

  function automatic logic [7:0] rand_text_byte();
    string alpha = "GETPOSHTFNDgetposhtfnd /";
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 255);
    return alpha[$urandom_range(0, alpha.len() - 1)];
  endfunction

  // caps: 0 lower, 1 upper, 2 mixed
  function automatic void add_text(input string s, input int caps);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= 8'h61 && c <= 8'h7A && (caps == 1 || (caps == 2 && $urandom_range(0, 1) == 1)))
        c = c - 8'h20;
      payload_bytes.push_back(c);
    end
  endfunction

  function automatic void add_tls(input bit hello);
    payload_bytes.push_back(TLS_HANDSHAKE);
    payload_bytes.push_back(8'h03);
    payload_bytes.push_back(8'h01);
    payload_bytes.push_back($urandom_range(0, 255));
    payload_bytes.push_back($urandom_range(0, 255));
    payload_bytes.push_back(hello ? TLS_CLIENT_HELLO : 8'($urandom_range(2, 255)));
    repeat (4) payload_bytes.push_back($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_port();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return port_cfg.https_port;
    if (r == 2) return port_cfg.ftp_port;
    if (r == 3) return port_cfg.dns_port;
    return $urandom_range(0, 65535);
  endfunction

  function automatic int pick_len_nibble();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 5;
    if (r < 9) return $urandom_range(6, 15);
    return $urandom_range(0, 4);
  endfunction

  // cut = 0 or cut >= frame size keeps the whole frame, otherwise the frame ends after cut bytes
  function automatic void push_frame(input logic [1:0] link, input int ihl4,
                                     input logic [7:0] prot, input int doff,
                                     input logic [15:0] sport, input logic [15:0] dport,
                                     input int cut);
    logic [7:0] f[$];
    logic [7:0] r8;
    in_item_t   it;
    int         n;
    repeat (12) f.push_back($urandom_range(0, 255));
    if (link != LINK_ETH) begin
      f.push_back($urandom_range(9, 255));
      f.push_back($urandom_range(0, 255));
    end
    if (link == LINK_NONE) begin
      f.push_back($urandom_range(9, 255));
      f.push_back($urandom_range(0, 255));
    end else begin
      f.push_back(IPV4_TYPE[15:8]);
      f.push_back(IPV4_TYPE[7:0]);
    end
    r8 = $urandom_range(0, 255);
    f.push_back({($urandom_range(0, 7) == 0) ? r8[7:4] : 4'h4, ihl4[3:0]});
    repeat (8) f.push_back($urandom_range(0, 255));
    f.push_back(prot);
    repeat (10) f.push_back($urandom_range(0, 255));
    if (ihl4 > 5) repeat ((ihl4 - 5) * 4) f.push_back($urandom_range(0, 255));
    if (prot == PROTO_TCP || prot == PROTO_UDP) begin
      f.push_back(sport[15:8]); f.push_back(sport[7:0]);
      f.push_back(dport[15:8]); f.push_back(dport[7:0]);
    end
    if (prot == PROTO_TCP) begin
      repeat (8) f.push_back($urandom_range(0, 255));
      r8 = $urandom_range(0, 255);
      f.push_back({doff[3:0], r8[3:0]});
      repeat (7) f.push_back($urandom_range(0, 255));
      if (doff > 5) repeat ((doff - 5) * 4) f.push_back($urandom_range(0, 255));
    end else if (prot == PROTO_UDP) begin
      repeat (4) f.push_back($urandom_range(0, 255));
    end
    foreach (payload_bytes[i]) f.push_back(payload_bytes[i]);
    n = (cut > 0 && cut < f.size()) ? cut : f.size();
    for (int i = 0; i < n; i++) begin
      it.data_byte = f[i];
      it.end_of_packet = (i == n - 1);
      byte_backlog.push_back(it);
    end
    bytes_queued += n;
  endfunction

  function automatic void queue_random_frame();
    logic [1:0] link;
    logic [7:0] prot;
    int         r;
    r = $urandom_range(0, 9);
    link = (r == 0) ? LINK_NONE : (r < 6) ? LINK_ETH : LINK_COOKED;
    r = $urandom_range(0, 9);
    prot = (r < 4) ? PROTO_TCP : (r < 8) ? PROTO_UDP : 8'($urandom_range(0, 255));
    payload_bytes.delete();
    r = $urandom_range(0, 9);
    if (r < 2) begin
      add_tls($urandom_range(0, 3) != 0);
    end else begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 6)) payload_bytes.push_back(rand_text_byte());
      case ($urandom_range(0, 6))
        0: add_text("get ", $urandom_range(0, 2));
        1: add_text("post ", $urandom_range(0, 2));
        2: add_text("http/", $urandom_range(0, 2));
        3: add_text("ftp", $urandom_range(0, 2));
        4: add_text("dns", $urandom_range(0, 2));
        default: ;
      endcase
    end
    repeat ($urandom_range(0, 24)) payload_bytes.push_back(rand_text_byte());
    push_frame(link, pick_len_nibble(), prot, pick_len_nibble(), pick_port(), pick_port(),
               ($urandom_range(0, 5) == 0) ? $urandom_range(1, 90) : 0);
  endfunction

  // ---- configuration and phase control ----

  task automatic write_port(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HTTPS_PORT: port_cfg.https_port = val;
      CFG_FTP_PORT:   port_cfg.ftp_port   = val;
      CFG_DNS_PORT:   port_cfg.dns_port   = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || in_valid || expected_summaries.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_mixed_phase(input logic [15:0] https, input logic [15:0] ftp,
                                 input logic [15:0] dns, input int send_odds,
                                 input int hold_odds);
    int start_bytes;
    drain();
    write_port(CFG_HTTPS_PORT, https);
    write_port(CFG_FTP_PORT, ftp);
    write_port(CFG_DNS_PORT, dns);
    settings_used++;
    @(negedge clk);
    gap_odds = send_odds;
    stall_odds = hold_odds;
    start_bytes = bytes_queued;
    do queue_random_frame();
    while (bytes_queued - start_bytes < 20);
  endtask

  // ---- input driver ----

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (classify_byte(in_item, predicted)) expected_summaries.push_back(predicted);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
          send_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (byte_backlog.size() != 0) begin
          in_valid <= 1'b1;
          in_item  <= byte_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- output monitor ----

  function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_summaries.size() == 0) begin
          $error("summary with no frame outstanding");
          mismatches++;
        end else begin
          want = expected_summaries.pop_front();
          compare_field("frame_valid", want.frame_valid, out_item.frame_valid);
          compare_field("link_kind", want.link_kind, out_item.link_kind);
          compare_field("source_address", want.source_address, out_item.source_address);
          compare_field("destination_address", want.destination_address,
                        out_item.destination_address);
          compare_field("network_kind", want.network_kind, out_item.network_kind);
          compare_field("transport_kind", want.transport_kind, out_item.transport_kind);
          compare_field("source_port", want.source_port, out_item.source_port);
          compare_field("destination_port", want.destination_port, out_item.destination_port);
          compare_field("application_kind", want.application_kind, out_item.application_kind);
          compare_field("payload_length", want.payload_length, out_item.payload_length);
          app_count[want.application_kind]++;
          summaries_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        stall_left = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d summaries outstanding",
               cycle_count, expected_summaries.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---- stimulus ----

  initial begin
    clear_flow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    gap_odds = 6;
    stall_odds = 6;

    // short, truncated and malformed frames
    payload_bytes.delete();
    push_frame(LINK_ETH, 5, PROTO_TCP, 5, 16'd5000, 16'd443, 1);
    push_frame(LINK_ETH, 5, PROTO_TCP, 5, 16'd5000, 16'd443, 15);
    push_frame(LINK_NONE, 5, PROTO_TCP, 5, 16'd443, 16'd443, 0);
    push_frame(LINK_ETH, 4, PROTO_TCP, 5, 16'd443, 16'd443, 0);
    push_frame(LINK_ETH, 5, PROTO_TCP, 5, 16'd443, 16'd443, 30);
    push_frame(LINK_ETH, 5, PROTO_TCP, 5, 16'd5000, 16'd80, 44);
    push_frame(LINK_COOKED, 5, PROTO_UDP, 5, 16'd5000, 16'd80, 16 + 20 + 8);
    push_frame(LINK_COOKED, 5, PROTO_UDP, 5, 16'd5000, 16'd80, 16 + 20 + 7);
    // header past the frame end
    push_frame(LINK_COOKED, 5, PROTO_TCP, 15, 16'd5000, 16'd80, 16 + 20 + 30);
    push_frame(LINK_ETH, 5, PROTO_ICMP, 5, 16'd0, 16'd0, 0);
    push_frame(LINK_ETH, 5, PROTO_TCP, 5, 16'd5000, 16'd21, 0);
    add_text("hello", 0);
    push_frame(LINK_ETH, 5, PROTO_TCP, 5, 16'd443, 16'd5000, 0);
    push_frame(LINK_COOKED, 5, PROTO_UDP, 5, 16'd5000, 16'd53, 0);
    push_frame(LINK_ETH, 15, PROTO_TCP, 15, 16'd5000, 16'd80, 0);
    // payload cues
    payload_bytes.delete();
    add_text("get /index.html", 0);
    push_frame(LINK_ETH, 5, PROTO_TCP, 0, 16'd5000, 16'd80, 0);
    payload_bytes.delete();
    add_text("post /form http/1.1", 1);
    push_frame(LINK_COOKED, 5, PROTO_TCP, 5, 16'd5000, 16'd80, 0);
    payload_bytes.delete();
    add_text("xx http/1.0", 2);
    push_frame(LINK_ETH, 6, PROTO_TCP, 7, 16'd5000, 16'd80, 0);
    payload_bytes.delete();
    add_text("user ftp", 0);
    push_frame(LINK_ETH, 5, PROTO_TCP, 5, 16'd5000, 16'd80, 0);
    payload_bytes.delete();
    add_text("query dns", 1);
    push_frame(LINK_COOKED, 5, PROTO_UDP, 5, 16'd5000, 16'd80, 0);
    payload_bytes.delete();
    add_tls(1'b1);
    push_frame(LINK_ETH, 5, PROTO_TCP, 5, 16'd5000, 16'd80, 0);
    payload_bytes.delete();
    add_tls(1'b0);
    push_frame(LINK_ETH, 5, PROTO_TCP, 5, 16'd5000, 16'd80, 0);

    run_mixed_phase(16'd0, 16'hFFFF, $urandom_range(0, 65535), 4, 4);
    write_port(CFG_UNUSED, $urandom_range(0, 65535));
    run_mixed_phase(16'hFFFF, 16'd0, 16'hFFFF, 0, 3);
    run_mixed_phase($urandom_range(0, 65535), $urandom_range(0, 65535), 16'd0, 8, 0);
    run_mixed_phase($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), 3, 10);

    run_mixed_phase(HTTPS_PORT_RST, FTP_PORT_RST, DNS_PORT_RST, 0, 0);
    drain();
    repeat (10) @(posedge clk);

    $display("Checked %0d frame summaries over %0d bytes, %0d port settings",
             summaries_checked, bytes_sent, settings_used);
    $display("Classes: unknown %0d, https %0d, http %0d, ftp %0d, dns %0d",
             app_count[APP_UNKNOWN], app_count[APP_HTTPS], app_count[APP_HTTP],
             app_count[APP_FTP], app_count[APP_DNS]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
